// ----- hdl/qte_pkg.sv -----
// qte_pkg: shared types, constants and arithmetic helpers for the
// quaternion to Euler angle converter. No dependencies.
`default_nettype none
package qte_pkg;

   localparam int CordicSteps = 16;
   localparam int AtanEntries = 24;
   localparam int RootSteps   = 32;
   localparam int QueueDepth  = 4;

   localparam logic signed [29:0] AtanTab [0:AtanEntries-1] = '{
      30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121,
      30'sd3750058,  30'sd1876857,  30'sd938658,   30'sd469357,
      30'sd234682,   30'sd117342,   30'sd58671,    30'sd29335,
      30'sd14668,    30'sd7334,     30'sd3667,     30'sd1833,
      30'sd917,      30'sd458,      30'sd229,      30'sd115,
      30'sd57,       30'sd29,       30'sd14,       30'sd7
   };

   localparam logic signed [29:0] HalfTurn  = 30'sd188743680;
   localparam logic signed [43:0] PoleThr   = 44'sd535797170176;
   localparam logic signed [43:0] PoleScale = 44'sd1000;
   localparam logic [62:0]        Q60One    = 63'h1000_0000_0000_0000;
   localparam logic signed [33:0] Q30One    = 34'sd1073741824;
   localparam logic [16:0]        HeadLim   = 17'd46080;
   localparam logic [16:0]        BankLim   = 17'd23040;
   localparam logic [16:0]        AttLim    = 17'd11520;
   localparam logic signed [14:0] AttPole   = 15'sd11520;

   typedef enum logic [1:0] {
      PoleNone  = 2'd0,
      PoleNorth = 2'd1,
      PoleSouth = 2'd2
   } pole_type;

   typedef struct packed {
      pole_type          pole;
      logic signed [31:0] s;
      logic signed [33:0] hd_y;
      logic signed [33:0] hd_x;
      logic signed [33:0] bk_y;
      logic signed [33:0] bk_x;
   } qte_entry_type;

   typedef struct packed {
      logic               zero;
      logic signed [35:0] x;
      logic signed [35:0] y;
      logic signed [29:0] z;
   } cordic_type;

   typedef struct packed {
      pole_type           pole;
      logic signed [31:0] s;
      logic [62:0]        rem;
      logic [62:0]        root;
      cordic_type         hd;
      cordic_type         bk;
      cordic_type         at;
   } qte_stage_type;

   function automatic logic signed [35:0] shr_tz(logic signed [35:0] v, int k);
      logic signed [35:0] m;
      m = (v < 0) ? -v : v;
      m = m >>> k;
      return (v < 0) ? -m : m;
   endfunction

   function automatic cordic_type cordic_pre(logic signed [35:0] yv,
                                             logic signed [35:0] xv);
      cordic_type c;
      c.zero = (xv == 36'sd0) && (yv == 36'sd0);
      c.x    = xv;
      c.y    = yv;
      c.z    = 30'sd0;
      if (xv < 0) begin
         c.z = (yv >= 0) ? HalfTurn : -HalfTurn;
         c.x = -xv;
         c.y = -yv;
      end
      return c;
   endfunction

   function automatic cordic_type cordic_step(cordic_type c, int i);
      cordic_type         r;
      logic signed [35:0] dx;
      logic signed [35:0] dy;
      r  = c;
      dx = shr_tz(c.y, i);
      dy = shr_tz(c.x, i);
      if (c.y >= 0) begin
         r.x = c.x + dx;
         r.y = c.y - dy;
         r.z = c.z + AtanTab[i];
      end else begin
         r.x = c.x - dx;
         r.y = c.y + dy;
         r.z = c.z - AtanTab[i];
      end
      return r;
   endfunction

   function automatic logic signed [17:0] round_out(logic signed [31:0] z,
                                                    logic [16:0] lim);
      logic [31:0] m;
      logic [18:0] r;
      m = (z < 0) ? 32'(-z) : 32'(z);
      r = 19'((m + 32'd4096) >> 13);
      if (r > {2'b00, lim}) begin
         r = {2'b00, lim};
      end
      return (z < 0) ? -$signed({1'b0, r[16:0]}) : $signed({1'b0, r[16:0]});
   endfunction

endpackage
`default_nettype wire

// ----- hdl/qte_front.sv -----
// qte_front: registers requests, forms the quaternion products, runs the
// pole test and builds queue entries. Depends on qte_pkg.
`default_nettype none
module qte_front
   import qte_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   output logic                     full,
   input  wire logic signed [15:0]  quat_x,
   input  wire logic signed [15:0]  quat_y,
   input  wire logic signed [15:0]  quat_z,
   input  wire logic signed [15:0]  quat_w,
   output logic                     ent_valid,
   input  wire logic                ent_ready,
   output qte_entry_type            ent
);

   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   logic signed [15:0] x1_ff, y1_ff, z1_ff, w1_ff;
   logic signed [15:0] x2_ff, w2_ff;
   logic signed [31:0] xy_ff, zw_ff, yw_ff, xz_ff, yy_ff, zz_ff, xx_ff, xw_ff, yz_ff;
   logic signed [15:0] x3_ff, w3_ff;
   logic signed [32:0] t_ff, t_in;
   logic signed [33:0] hy_ff, hx_ff, by_ff, bx_ff;
   logic signed [33:0] hy_in, hx_in, by_in, bx_in;
   logic signed [43:0] t1000;

   assign rdy3 = !v3_ff || ent_ready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign full = !rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= push;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_comb begin
      t_in  = 33'(xy_ff) + 33'(zw_ff);
      hy_in = 34'(2) * (34'(yw_ff) - 34'(xz_ff));
      hx_in = Q30One - 34'(2) * (34'(yy_ff) + 34'(zz_ff));
      by_in = 34'(2) * (34'(xw_ff) - 34'(yz_ff));
      bx_in = Q30One - 34'(2) * (34'(xx_ff) + 34'(zz_ff));
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         x1_ff <= quat_x;
         y1_ff <= quat_y;
         z1_ff <= quat_z;
         w1_ff <= quat_w;
      end
      if (rdy2) begin
         x2_ff <= x1_ff;
         w2_ff <= w1_ff;
         xy_ff <= x1_ff * y1_ff;
         zw_ff <= z1_ff * w1_ff;
         yw_ff <= y1_ff * w1_ff;
         xz_ff <= x1_ff * z1_ff;
         yy_ff <= y1_ff * y1_ff;
         zz_ff <= z1_ff * z1_ff;
         xx_ff <= x1_ff * x1_ff;
         xw_ff <= x1_ff * w1_ff;
         yz_ff <= y1_ff * z1_ff;
      end
      if (rdy3) begin
         x3_ff <= x2_ff;
         w3_ff <= w2_ff;
         t_ff  <= t_in;
         hy_ff <= hy_in;
         hx_ff <= hx_in;
         by_ff <= by_in;
         bx_ff <= bx_in;
      end
   end

   assign t1000     = 44'(t_ff) * PoleScale;
   assign ent_valid = v3_ff;

   always_comb begin
      ent.s    = 32'(t_ff) <<< 1;
      ent.bk_y = by_ff;
      ent.bk_x = bx_ff;
      ent.hd_y = hy_ff;
      ent.hd_x = hx_ff;
      ent.pole = PoleNone;
      if (t1000 > PoleThr) begin
         ent.pole = PoleNorth;
      end else if (t1000 < -PoleThr) begin
         ent.pole = PoleSouth;
      end
      if (ent.pole != PoleNone) begin
         ent.hd_y = 34'(x3_ff) <<< 15;
         ent.hd_x = 34'(w3_ff) <<< 15;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/qte_queue.sv -----
// qte_queue: short first-in first-out buffer of classified entries between
// the front and back pipelines. Depends on qte_pkg.
`default_nettype none
module qte_queue
   import qte_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_valid,
   output logic               wr_ready,
   input  wire qte_entry_type wr_data,
   output logic               rd_valid,
   input  wire logic          rd_ready,
   output qte_entry_type      rd_data
);

   localparam int PtrW = $clog2(QueueDepth);

   qte_entry_type       mem_ff [QueueDepth];
   logic [PtrW-1:0]     wp_ff, rp_ff;
   logic [PtrW:0]       cnt_ff;
   logic                wr_en, rd_en;

   assign wr_ready = (cnt_ff != (PtrW+1)'(QueueDepth));
   assign rd_valid = (cnt_ff != '0);
   assign wr_en    = wr_valid && wr_ready;
   assign rd_en    = rd_valid && rd_ready;
   assign rd_data  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + 1'b1;
         if (rd_en) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (PtrW+1)'(wr_en) - (PtrW+1)'(rd_en);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wp_ff] <= wr_data;
   end

endmodule
`default_nettype wire

// ----- hdl/qte_back.sv -----
// qte_back: square root and CORDIC pipeline that turns queue entries into
// rounded angles, ending in the result register. Depends on qte_pkg.
`default_nettype none
module qte_back
   import qte_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               ent_valid,
   output logic                    ent_ready,
   input  wire qte_entry_type      ent,
   output logic                    empty,
   input  wire logic               pop,
   output logic signed [15:0]      bank_angle,
   output logic signed [16:0]      heading_angle,
   output logic signed [14:0]      attitude_angle,
   output logic [1:0]              pole_case
);

   localparam int AttPreSt  = 2 + RootSteps;
   localparam int CordicSt0 = AttPreSt + 1;
   localparam int NumStages = CordicSt0 + CordicSteps;

   qte_stage_type       st_ff [NumStages];
   qte_stage_type       st_in [NumStages];
   logic [NumStages-1:0] v_ff;
   logic [NumStages:0]   rdy;

   logic                out_v_ff;
   logic signed [15:0]  bank_ff, bank_in;
   logic signed [16:0]  head_ff, head_in;
   logic signed [14:0]  att_ff, att_in;
   logic [1:0]          pole_ff;

   logic [29:0]         smag;
   logic [59:0]         ssq;

   assign rdy[NumStages] = !out_v_ff || pop;
   assign ent_ready      = rdy[0];

   assign smag = (ent.s < 0) ? 30'(-ent.s) : 30'(ent.s);
   assign ssq  = smag * smag;

   always_comb begin
      st_in[0].pole = ent.pole;
      st_in[0].s    = ent.s;
      st_in[0].rem  = 63'(ssq);
      st_in[0].root = '0;
      st_in[0].hd   = cordic_pre(36'(ent.hd_y), 36'(ent.hd_x));
      st_in[0].bk   = cordic_pre(36'(ent.bk_y), 36'(ent.bk_x));
      st_in[0].at   = '0;
   end

   genvar k;
   for (k = 0; k < NumStages; k++) begin : g_st
      assign rdy[k] = !v_ff[k] || rdy[k+1];

      if (k > 0) begin : g_calc
         always_comb begin
            logic [62:0] bit_v;
            logic [62:0] trial;
            st_in[k] = st_ff[k-1];
            bit_v    = '0;
            trial    = '0;
            if (k == 1) begin
               st_in[k].rem  = Q60One - st_ff[k-1].rem;
               st_in[k].root = '0;
            end else if (k < AttPreSt) begin
               bit_v = 63'(1) << (2 * (RootSteps + 1 - k));
               trial = st_ff[k-1].root + bit_v;
               if (st_ff[k-1].rem >= trial) begin
                  st_in[k].rem  = st_ff[k-1].rem - trial;
                  st_in[k].root = (st_ff[k-1].root >> 1) + bit_v;
               end else begin
                  st_in[k].root = st_ff[k-1].root >> 1;
               end
            end else if (k == AttPreSt) begin
               st_in[k].at = cordic_pre(36'(st_ff[k-1].s),
                                        $signed({5'd0, st_ff[k-1].root[30:0]}));
            end else begin
               st_in[k].hd = cordic_step(st_ff[k-1].hd, k - CordicSt0);
               st_in[k].bk = cordic_step(st_ff[k-1].bk, k - CordicSt0);
               st_in[k].at = cordic_step(st_ff[k-1].at, k - CordicSt0);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            if (k == 0) v_ff[k] <= ent_valid;
            else        v_ff[k] <= v_ff[(k > 0) ? k-1 : 0];
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[k]) st_ff[k] <= st_in[k];
      end
   end

   always_comb begin
      qte_stage_type      f;
      logic signed [31:0] hz, bz, az;
      logic signed [17:0] r;
      f  = st_ff[NumStages-1];
      hz = f.hd.zero ? 32'sd0 : 32'(f.hd.z);
      bz = f.bk.zero ? 32'sd0 : 32'(f.bk.z);
      az = f.at.zero ? 32'sd0 : 32'(f.at.z);
      unique case (f.pole)
         PoleNorth: begin
            r       = round_out(hz <<< 1, HeadLim);
            head_in = r[16:0];
            att_in  = AttPole;
            bank_in = '0;
         end
         PoleSouth: begin
            r       = round_out(-(hz <<< 1), HeadLim);
            head_in = r[16:0];
            att_in  = -AttPole;
            bank_in = '0;
         end
         default: begin
            r       = round_out(hz, HeadLim);
            head_in = r[16:0];
            r       = round_out(az, AttLim);
            att_in  = r[14:0];
            r       = round_out(bz, BankLim);
            bank_in = r[15:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (rdy[NumStages]) begin
         out_v_ff <= v_ff[NumStages-1];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[NumStages]) begin
         bank_ff <= bank_in;
         head_ff <= head_in;
         att_ff  <= att_in;
         pole_ff <= st_ff[NumStages-1].pole;
      end
   end

   assign empty          = !out_v_ff;
   assign bank_angle     = bank_ff;
   assign heading_angle  = head_ff;
   assign attitude_angle = att_ff;
   assign pole_case      = pole_ff;

endmodule
`default_nettype wire

// ----- hdl/quaternion_to_euler_core.sv -----
// Quaternion to Euler angle converter, top level.
// Instantiates qte_front, qte_queue and qte_back; uses qte_pkg.
//
// Takes one Q1.15 quaternion per cycle while full is low and returns bank,
// heading and attitude in 1/128 degree plus a pole flag, one result per
// request in order. Sustained rate is one request per clock while the
// result side pops. A request passes through 3 front stages, the queue, and
// 35 + CORDIC steps back stages plus the result register; the 32-step square
// root feeding the asin path makes up most of them. Stalls on the result
// side back up through the queue and pipeline bubbles before full rises.
`default_nettype none
module quaternion_to_euler_core
   import qte_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   output logic                    full,
   input  wire logic signed [15:0] req_quat_x,
   input  wire logic signed [15:0] req_quat_y,
   input  wire logic signed [15:0] req_quat_z,
   input  wire logic signed [15:0] req_quat_w,
   output logic                    empty,
   input  wire logic               pop,
   output logic signed [15:0]      rsp_bank_angle,
   output logic signed [16:0]      rsp_heading_angle,
   output logic signed [14:0]      rsp_attitude_angle,
   output logic [1:0]              rsp_pole_case
);

   logic          f_valid, f_ready, q_valid, q_ready;
   qte_entry_type f_ent, q_ent;

   qte_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .quat_x    (req_quat_x),
      .quat_y    (req_quat_y),
      .quat_z    (req_quat_z),
      .quat_w    (req_quat_w),
      .ent_valid (f_valid),
      .ent_ready (f_ready),
      .ent       (f_ent)
   );

   qte_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_data  (f_ent),
      .rd_valid (q_valid),
      .rd_ready (q_ready),
      .rd_data  (q_ent)
   );

   qte_back u_back (
      .clock          (clock),
      .reset          (reset),
      .ent_valid      (q_valid),
      .ent_ready      (q_ready),
      .ent            (q_ent),
      .empty          (empty),
      .pop            (pop),
      .bank_angle     (rsp_bank_angle),
      .heading_angle  (rsp_heading_angle),
      .attitude_angle (rsp_attitude_angle),
      .pole_case      (rsp_pole_case)
   );

endmodule
`default_nettype wire

// ----- tb/sv/quaternion_to_euler_core_tb.sv -----
// Testbench for quaternion_to_euler_core: directed table then random quaternions,
// each result checked against its table entry or an in-bench CORDIC angle predictor.
// Depends on qte_pkg and the core RTL only.
`default_nettype none
module quaternion_to_euler_core_tb
   import qte_pkg::*;
   ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumRandom = 1600;
   localparam int CycleLimit = 400000;
   localparam int Steps = 16;
   localparam longint DegUnits = 1048576;
   localparam longint Q30 = 64'sd1073741824;
   localparam longint PoleLimit = 64'sd535797170176;
   localparam longint ArcTab [0:23] = '{
      47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
      234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29, 14, 7
   };

   typedef struct packed {
      logic signed [15:0] bank;
      logic signed [16:0] head;
      logic signed [14:0] att;
      pole_type           pole;
   } angles_type;

   typedef struct {
      logic signed [15:0] x, y, z, w;
      bit                 typed;
      angles_type         want;
   } quat_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   logic signed [15:0] req_quat_x = '0, req_quat_y = '0, req_quat_z = '0, req_quat_w = '0;
   logic signed [15:0] rsp_bank_angle;
   logic signed [16:0] rsp_heading_angle;
   logic signed [14:0] rsp_attitude_angle;
   logic [1:0]         rsp_pole_case;

   angles_type angles_due[$];
   int         mismatches = 0;
   int         cycles = 0;
   bit         rsp_calm = 1'b0;
   int         rsp_wait = 0;

   quaternion_to_euler_core i_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint trunc_shift(longint v, int k);
      return (v < 0) ? -((-v) >>> k) : (v >>> k);
   endfunction

   function automatic longint floor_root(bit [63:0] n);
      bit [63:0] r = 0;
      bit [63:0] b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint vector_angle(longint yv, longint xv);
      longint acc = 0;
      longint dx, dy;
      if (xv == 0 && yv == 0) return 0;
      if (xv < 0) begin
         acc = (yv >= 0) ? 180 * DegUnits : -180 * DegUnits;
         xv = -xv;
         yv = -yv;
      end
      for (int i = 0; i < Steps; i++) begin
         dx = trunc_shift(yv, i);
         dy = trunc_shift(xv, i);
         if (yv >= 0) begin
            xv += dx; yv -= dy; acc += ArcTab[i];
         end else begin
            xv -= dx; yv += dy; acc -= ArcTab[i];
         end
      end
      return acc;
   endfunction

   function automatic longint degree_units(longint a, longint lim);
      longint m = (a < 0) ? -a : a;
      longint r = (m + 4096) >>> 13;
      if (a < 0) r = -r;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic angles_type euler_of(longint x, longint y, longint z, longint w);
      angles_type o;
      longint t = x * y + z * w;
      longint a, s, c;
      o.bank = '0;
      if (1000 * t > PoleLimit || 1000 * t < -PoleLimit) begin
         a = 2 * vector_angle(x * 32768, w * 32768);
         if (1000 * t > PoleLimit) begin
            o.pole = PoleNorth;
            o.att = 15'sd11520;
         end else begin
            o.pole = PoleSouth;
            o.att = -15'sd11520;
            a = -a;
         end
         o.head = 17'(degree_units(a, 46080));
      end else begin
         s = 2 * t;
         c = floor_root((64'd1 << 60) - 64'(s * s));
         o.pole = PoleNone;
         o.head = 17'(degree_units(vector_angle(2 * (y * w - x * z),
                                                Q30 - 2 * (y * y + z * z)), 46080));
         o.att = 15'(degree_units(vector_angle(s, c), 11520));
         o.bank = 16'(degree_units(vector_angle(2 * (x * w - y * z),
                                                Q30 - 2 * (x * x + z * z)), 23040));
      end
      return o;
   endfunction

   function automatic quat_row_type random_quat();
      quat_row_type q;
      int m = $urandom_range(0, 3);
      q.typed = 1'b0;
      q.x = 16'($urandom); q.y = 16'($urandom);
      q.z = 16'($urandom); q.w = 16'($urandom);
      if (m == 1) begin
         q.x = 16'($signed(q.x) >>> 2); q.y = 16'($signed(q.y) >>> 2);
         q.z = 16'($signed(q.z) >>> 2); q.w = 16'($signed(q.w) >>> 2);
      end else if (m == 2) begin
         q.x = 16'($urandom_range(22500, 23800));
         q.y = $urandom_range(0, 1) ? q.x : -q.x;
         q.z = 16'($signed(q.z) >>> 6);
         q.w = $urandom_range(0, 1) ? q.z : -q.z;
         q.y = q.y + 16'($signed(16'($urandom)) >>> 8);
      end
      return q;
   endfunction

   // response side: accept, check, then draw the next stall
   always @(posedge clock) begin
      angles_type got, want;
      if (!reset) begin
         if (pop && !empty) begin
            got = '{rsp_bank_angle, rsp_heading_angle, rsp_attitude_angle,
                    pole_type'(rsp_pole_case)};
            if (angles_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", got);
            end else begin
               want = angles_due.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
               end
            end
            if ($urandom_range(0, 99) == 0) rsp_calm = !rsp_calm;
            rsp_wait = rsp_calm ? 0 : $urandom_range(0, 8);
            pop <= (rsp_wait == 0);
         end else if (!pop) begin
            if (rsp_wait <= 1) pop <= 1'b1;
            else rsp_wait--;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic send_request(quat_row_type q);
      int gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_quat_x <= q.x; req_quat_y <= q.y; req_quat_z <= q.z; req_quat_w <= q.w;
      do @(posedge clock); while (full);
      angles_due.insert(angles_due.size(),
                        q.typed ? q.want : euler_of(q.x, q.y, q.z, q.w));
   endtask

   quat_row_type quat_table[$] = '{
      '{16'sd0, 16'sd0, 16'sd0, 16'sd32767, 1'b1, '{16'sd0, 17'sd0, 15'sd0, PoleNone}},
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd0, 17'sd0, 15'sd0, PoleNone}},
      '{16'sd23170, 16'sd23170, 16'sd0, 16'sd0, 1'b0, '0},
      '{16'sd23170, -16'sd23170, 16'sd0, 16'sd0, 1'b0, '0},
      '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0},
      '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
      '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 1'b0, '0},
      '{16'sd0, 16'sd32767, 16'sd0, 16'sd0, 1'b0, '0},
      '{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0},
      '{16'sd0, 16'sd0, 16'sd32767, 16'sd0, 1'b0, '0},
      '{16'sd0, 16'sd0, -16'sd32768, 16'sd0, 1'b0, '0},
      '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384, 1'b0, '0},
      '{16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384, 1'b0, '0},
      '{16'sd23100, 16'sd23100, 16'sd1000, 16'sd1000, 1'b0, '0},
      '{16'sd23000, 16'sd23263, 16'sd0, 16'sd0, 1'b0, '0},
      '{-16'sd23170, 16'sd23170, 16'sd0, -16'sd1, 1'b0, '0},
      '{16'sd0, 16'sd0, 16'sd0, -16'sd32768, 1'b0, '0},
      '{16'sd1, -16'sd1, 16'sd1, -16'sd1, 1'b0, '0},
      '{16'sd12345, -16'sd6789, 16'sd23456, 16'sd11111, 1'b0, '0},
      '{-16'sd21845, 16'sd21845, -16'sd21845, 16'sd21845, 1'b0, '0}
   };

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      pop <= 1'b1;
      foreach (quat_table[i]) send_request(quat_table[i]);
      repeat (NumRandom) send_request(random_quat());
      push <= 1'b0;
      while (angles_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && angles_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
